/* src/assert_macros.svh */
// Assertion helper macros for the time table search block.
// Each macro expects clk_i and rst_ni to be visible in the calling module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside of reset.
`define STPS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Condition that must never be true outside of reset.
`define STPS_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

/* src/stps_pkg.sv */
// Shared types and constants for the sorted time predecessor search block.
// Used by the controller, the datapath and the top level.
package stps_pkg;

  // Fixed field widths.
  localparam int TIME_W          = 40;
  localparam int CNT_REG_W       = 11;
  localparam int FIDX_W          = 10;
  localparam int DEF_MAX_ENTRIES = 1024;

  // Stream payload widths, padded to whole bytes.
  localparam int IN_TDATA_W  = 56;
  localparam int OUT_TDATA_W = 16;

  // Configuration port.
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_ENTRY_COUNT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_END_TIME    = 1'b1;

  // Item kinds carried in the input tuser.
  typedef enum logic {
    OP_WRITE = 1'b0,
    OP_QUERY = 1'b1
  } op_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic write;      // store the accepted entry time
    logic load;       // capture an accepted query and set up the interval
    logic rd_first;   // read entry 0 instead of the next midpoint
    logic step;       // narrow the interval using the last read entry
    logic out_load;   // load the output register
    logic out_found;  // hit flag for the loaded result
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic miss;  // empty table, query before entry 0 or at or past end time
    logic more;  // interval still spans more than one entry after this cycle
  } status_t;

endpackage

/* src/stps_datapath.sv */
// Datapath of the time table search: table memory, config registers,
// search interval registers and the output payload register. Uses stps_pkg.
`include "assert_macros.svh"

module stps_datapath #(
  parameter int MaxEntries = stps_pkg::DEF_MAX_ENTRIES
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  stps_pkg::cmd_t                cmd_i,
  output stps_pkg::status_t             status_o,
  input  logic [stps_pkg::FIDX_W-1:0]   entry_index_i,
  input  logic [stps_pkg::TIME_W-1:0]   time_value_i,
  input  logic                          cfg_we_i,
  input  logic [stps_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [stps_pkg::TIME_W-1:0]   cfg_data_i,
  output logic                          found_o,
  output logic [stps_pkg::FIDX_W-1:0]   frame_index_o
);
  import stps_pkg::*;

  localparam int IDX_W = (MaxEntries > 1) ? $clog2(MaxEntries) : 1;
  localparam int CNT_W = $clog2(MaxEntries + 1);

  logic [TIME_W-1:0]    frame_times [MaxEntries];
  logic [TIME_W-1:0]    rdata_q;
  logic [TIME_W-1:0]    time_q;
  logic [TIME_W-1:0]    end_time_q;
  logic [CNT_REG_W-1:0] entry_count_q;
  logic [IDX_W-1:0]     lo_q, lo_d, mid_q, mid_nx, rd_addr, wr_addr;
  logic [CNT_W-1:0]     hi_q, hi_d, diff_nx, n_clamped;
  logic                 go_right, slot_ok;
  logic                 found_q;
  logic [FIDX_W-1:0]    frame_index_q;

  // Configuration registers; the user must write them only while the block is idle, the block does not enforce it.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entry_count_q <= '0;
      end_time_q    <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_ENTRY_COUNT: entry_count_q <= cfg_data_i[CNT_REG_W-1:0];
        CFG_END_TIME:    end_time_q    <= cfg_data_i;
        default:         ;
      endcase
    end
  end

  // Entry count limited to the table depth.
  assign n_clamped = (32'(entry_count_q) > 32'(MaxEntries)) ? CNT_W'(MaxEntries)
                                                            : CNT_W'(entry_count_q);

  // Interval update: keep the upper half when the probed entry is at or before the query.
  assign go_right = (rdata_q <= time_q);
  assign lo_d     = (cmd_i.step && go_right)  ? mid_q               : lo_q;
  assign hi_d     = (cmd_i.step && !go_right) ? CNT_W'(mid_q)       : hi_q;
  assign diff_nx  = hi_d - CNT_W'(lo_d);
  assign mid_nx   = lo_d + IDX_W'(diff_nx >> 1);
  assign rd_addr  = cmd_i.rd_first ? '0 : mid_nx;

  assign status_o.more = (diff_nx > CNT_W'(1));
  assign status_o.miss = (hi_q == '0) || (time_q < rdata_q) || (time_q >= end_time_q);

  // Table write port; slots beyond the table depth are dropped.
  assign slot_ok = (32'(entry_index_i) < 32'(MaxEntries));
  assign wr_addr = IDX_W'(entry_index_i);

  always_ff @(posedge clk_i) begin
    if (cmd_i.write && slot_ok) begin
      frame_times[wr_addr] <= time_value_i;
    end
  end

  // Table read port with registered data.
  always_ff @(posedge clk_i) begin
    rdata_q <= frame_times[rd_addr];
    mid_q   <= rd_addr;
  end

  // Query time and search interval.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      time_q <= time_value_i;
      lo_q   <= '0;
      hi_q   <= n_clamped;
    end else if (cmd_i.step) begin
      lo_q <= lo_d;
      hi_q <= hi_d;
    end
  end

  // Output payload register.
  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      found_q       <= cmd_i.out_found;
      frame_index_q <= cmd_i.out_found ? FIDX_W'(lo_q) : '0;
    end
  end

  assign found_o       = found_q;
  assign frame_index_o = frame_index_q;

  `STPS_ASSERT(a_step_wide, cmd_i.step |-> (hi_q - CNT_W'(lo_q) > CNT_W'(1)), "narrow search step")
  `STPS_NEVER(a_write_load, cmd_i.write && cmd_i.load, "write and query in one cycle")

endmodule

/* src/stps_ctrl.sv */
// Controller state machine of the time table search: input handshake,
// search sequencing and the output valid flag. Uses stps_pkg.
`include "assert_macros.svh"

module stps_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  stps_pkg::op_e     in_op_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  input  stps_pkg::status_t status_i,
  output stps_pkg::cmd_t    cmd_o
);
  import stps_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_CHECK,
    S_SEARCH,
    S_RESULT
  } state_e;

  state_e state_q;
  logic   out_valid_q;
  logic   hit_q;
  logic   accept;
  logic   out_free;

  assign accept   = in_valid_i && (state_q == S_IDLE);
  assign out_free = !out_valid_q || out_ready_i;

  // Commands decoded from the current state and the input handshake.
  always_comb begin
    cmd_o           = '0;
    cmd_o.write     = accept && (in_op_i == OP_WRITE);
    cmd_o.load      = accept && (in_op_i == OP_QUERY);
    cmd_o.rd_first  = (state_q == S_IDLE);
    cmd_o.step      = (state_q == S_SEARCH);
    cmd_o.out_load  = (state_q == S_RESULT) && out_free;
    cmd_o.out_found = hit_q;
  end

  // State, hit flag and output valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      hit_q       <= 1'b0;
    end else begin
      if ((state_q == S_RESULT) && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (accept && (in_op_i == OP_QUERY)) begin
            state_q <= S_CHECK;
          end
        end
        S_CHECK: begin
          hit_q <= !status_i.miss;
          if (status_i.miss || !status_i.more) begin
            state_q <= S_RESULT;
          end else begin
            state_q <= S_SEARCH;
          end
        end
        S_SEARCH: begin
          if (!status_i.more) begin
            state_q <= S_RESULT;
          end
        end
        S_RESULT: begin
          if (out_free) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

  `STPS_ASSERT(a_query_busy, cmd_o.load |=> !in_ready_o, "query accepted but still ready")
  `STPS_ASSERT(a_load_free, cmd_o.out_load |-> out_free, "result overwrites an untaken result")

endmodule

/* src/sorted_time_predecessor_search_top.sv */
// Top level of the sorted time predecessor search block.
// Instantiates stps_ctrl and stps_datapath; uses stps_pkg.
//
// Usage: the slave stream carries items. tuser selects the kind: a write
// stores tdata time_value into table slot entry_index and gives no result;
// a query gives exactly one result on the master stream. A result carries
// found in tuser and frame_index in tdata: the index of the last table
// entry at or before the query time, or found low on a miss (empty table,
// query before entry 0, or query at or past end_time).
// The config port sets entry_count (index 0) and end_time (index 1); write
// it only while no query is in flight.
// A write leaves the controller idle. A query passes through the check state,
// k halving steps in the search state (one table read each) and the result
// state; leaving it raises result valid and lets the next item in. k is at
// most ceil(log2(n)), n the clamped entry count, zero on a miss or one entry.
// Reset clears the config registers and the control state; table contents
// are undefined until written. When the receiver stalls, the result waits
// in the output register and the next item is still taken; a second result
// then waits in the controller until the first transfer completes.
module sorted_time_predecessor_search_top #(
  parameter int MaxEntries = stps_pkg::DEF_MAX_ENTRIES
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // Input stream.
  input  logic                             s_axis_tvalid_i,
  output logic                             s_axis_tready_o,
  input  logic [stps_pkg::IN_TDATA_W-1:0]  s_axis_tdata_i,   // entry_index[9:0], time_value[49:10]
  input  logic                             s_axis_tuser_i,   // op
  // Result stream.
  output logic                             m_axis_tvalid_o,
  input  logic                             m_axis_tready_i,
  output logic [stps_pkg::OUT_TDATA_W-1:0] m_axis_tdata_o,   // frame_index[9:0]
  output logic                             m_axis_tuser_o,   // found
  // Configuration write port.
  input  logic                             cfg_we_i,
  input  logic [stps_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [stps_pkg::TIME_W-1:0]      cfg_data_i
);
  import stps_pkg::*;

  cmd_t              cmd;
  status_t           status;
  op_e               in_op;
  logic [FIDX_W-1:0] frame_index;
  logic              found;

  assign in_op = op_e'(s_axis_tuser_i);

  stps_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_op_i     (in_op),
    .in_ready_o  (s_axis_tready_o),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  stps_datapath #(
    .MaxEntries (MaxEntries)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .status_o      (status),
    .entry_index_i (s_axis_tdata_i[FIDX_W-1:0]),
    .time_value_i  (s_axis_tdata_i[FIDX_W+TIME_W-1:FIDX_W]),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .found_o       (found),
    .frame_index_o (frame_index)
  );

  // Result payload, padded to whole bytes.
  assign m_axis_tdata_o = {{(OUT_TDATA_W-FIDX_W){1'b0}}, frame_index};
  assign m_axis_tuser_o = found;

endmodule

/* bench/sorted_time_predecessor_search_top_tb.sv */
// Self-checking bench for sorted_time_predecessor_search_top: directed rows, then random
// time tables with stream idling, a long result hold-off and the largest entry count.
// Depends on stps_pkg and the RTL of the block; nothing else.
module sorted_time_predecessor_search_top_tb;
  import stps_pkg::*;

  localparam int MAX_ENTRIES   = DEF_MAX_ENTRIES;
  localparam int RANDOM_ITEMS  = 640;
  localparam int SETTLE_CYCLES = 24;     // idle time after the last result of a drain
  localparam int DRAIN_LIMIT   = 2000;
  localparam int HOLD_CYCLES   = 400;
  localparam int RUN_LIMIT     = 4_000_000;
  localparam int N_ROWS        = 25;
  localparam logic [TIME_W-1:0] TIME_MAX = '1;

  typedef struct packed {
    logic              found;
    logic [FIDX_W-1:0] frame_index;
  } result_t;

  typedef enum logic [1:0] {
    ROW_WRITE,
    ROW_QUERY,
    ROW_SET_COUNT,
    ROW_SET_END
  } row_kind_e;

  typedef struct packed {
    row_kind_e         kind;
    logic [FIDX_W-1:0] slot;
    logic [TIME_W-1:0] value;
    logic              checked;    // expected result typed into the row
    logic              exp_found;
    logic [FIDX_W-1:0] exp_index;
  } row_t;

  logic                   clk_i;
  logic                   rst_ni;
  logic                   s_axis_tvalid_i;
  logic                   s_axis_tready_o;
  logic [IN_TDATA_W-1:0]  s_axis_tdata_i;
  logic                   s_axis_tuser_i;
  logic                   m_axis_tvalid_o;
  logic                   m_axis_tready_i;
  logic [OUT_TDATA_W-1:0] m_axis_tdata_o;
  logic                   m_axis_tuser_o;
  logic                   cfg_we_i;
  logic [CFG_IDX_W-1:0]   cfg_idx_i;
  logic [TIME_W-1:0]      cfg_data_i;

  // Bench copy of the block state.
  logic [TIME_W-1:0]    table_copy [MAX_ENTRIES];
  logic [CNT_REG_W-1:0] count_copy;
  logic [TIME_W-1:0]    end_copy;

  // Times of the table built for the current phase.
  logic [TIME_W-1:0] phase_times [MAX_ENTRIES];
  int unsigned       phase_n;

  result_t results_due [$];
  int      mismatch_count;
  int      items_sent;
  bit      quiet;
  bit      hold_pending;

  // Directed rows: reset state, field extremes, every miss reason, an unsorted table.
  row_t directed_rows [N_ROWS] = '{
    '{ROW_WRITE,     10'd0,    40'h00_0000_0100, 1'b0, 1'b0, 10'd0},
    '{ROW_QUERY,     10'd0,    40'h00_0000_0100, 1'b1, 1'b0, 10'd0},  // empty table
    '{ROW_SET_COUNT, 10'd0,    40'd4,            1'b0, 1'b0, 10'd0},
    '{ROW_SET_END,   10'd0,    40'hFF_FFFF_FFFF, 1'b0, 1'b0, 10'd0},
    '{ROW_WRITE,     10'd1,    40'h00_0000_0200, 1'b0, 1'b0, 10'd0},
    '{ROW_WRITE,     10'd2,    40'h00_0000_0300, 1'b0, 1'b0, 10'd0},
    '{ROW_WRITE,     10'd3,    40'h00_0000_0400, 1'b0, 1'b0, 10'd0},
    '{ROW_WRITE,     10'd1023, 40'hFF_FFFF_FFFF, 1'b0, 1'b0, 10'd0},  // top slot, top time
    '{ROW_QUERY,     10'd1023, 40'h00_0000_0000, 1'b1, 1'b0, 10'd0},  // before entry 0
    '{ROW_QUERY,     10'd0,    40'h00_0000_00FF, 1'b1, 1'b0, 10'd0},
    '{ROW_QUERY,     10'd0,    40'h00_0000_0100, 1'b1, 1'b1, 10'd0},
    '{ROW_QUERY,     10'd0,    40'h00_0000_02FF, 1'b1, 1'b1, 10'd1},
    '{ROW_QUERY,     10'd0,    40'h00_0000_0400, 1'b1, 1'b1, 10'd3},
    '{ROW_QUERY,     10'd0,    40'hFF_FFFF_FFFE, 1'b1, 1'b1, 10'd3},
    '{ROW_QUERY,     10'd0,    40'hFF_FFFF_FFFF, 1'b1, 1'b0, 10'd0},  // at end time
    '{ROW_SET_END,   10'd0,    40'h00_0000_0300, 1'b0, 1'b0, 10'd0},
    '{ROW_QUERY,     10'd0,    40'h00_0000_02FF, 1'b1, 1'b1, 10'd1},
    '{ROW_QUERY,     10'd0,    40'h00_0000_0300, 1'b1, 1'b0, 10'd0},
    '{ROW_WRITE,     10'd2,    40'h00_0000_0050, 1'b0, 1'b0, 10'd0},  // table out of order
    '{ROW_QUERY,     10'd0,    40'h00_0000_0250, 1'b0, 1'b0, 10'd0},
    '{ROW_SET_END,   10'd0,    40'h00_0000_0000, 1'b0, 1'b0, 10'd0},
    '{ROW_QUERY,     10'd0,    40'h00_0000_0100, 1'b1, 1'b0, 10'd0},  // end time zero
    '{ROW_SET_COUNT, 10'd0,    40'd1,            1'b0, 1'b0, 10'd0},
    '{ROW_SET_END,   10'd0,    40'hFF_FFFF_FFFF, 1'b0, 1'b0, 10'd0},
    '{ROW_QUERY,     10'd0,    40'hFF_FFFF_FFFE, 1'b1, 1'b1, 10'd0}   // single entry
  };

  sorted_time_predecessor_search_top dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),   // entry_index[9:0], time_value[49:10]
    .s_axis_tuser_i  (s_axis_tuser_i),   // op
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),   // frame_index[9:0]
    .m_axis_tuser_o  (m_axis_tuser_o),   // found
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_data_i      (cfg_data_i)
  );

  // Clock with a period of 10.
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Binary search for the last entry at or before the query time.
  function automatic result_t find_predecessor(input logic [TIME_W-1:0] t);
    int unsigned n;
    int unsigned lo;
    int unsigned hi;
    int unsigned mid;
    result_t     res;
    res = '0;
    n = (count_copy > MAX_ENTRIES) ? MAX_ENTRIES : count_copy;
    if (n == 0 || t < table_copy[0] || t >= end_copy) begin
      return res;
    end
    lo = 0;
    hi = n;
    while (hi - lo > 1) begin
      mid = lo + (hi - lo) / 2;
      if (table_copy[mid] <= t) begin
        lo = mid;
      end else begin
        hi = mid;
      end
    end
    res.found = 1'b1;
    res.frame_index = FIDX_W'(lo);
    return res;
  endfunction

  function automatic logic [TIME_W-1:0] rand_time();
    return {8'($urandom_range(0, 255)), $urandom};
  endfunction

  // Offer one item and wait for its transfer. Returns at the accepting edge.
  task automatic send_item(input op_e op, input logic [FIDX_W-1:0] slot,
                           input logic [TIME_W-1:0] t, input bit typed,
                           input result_t typed_res);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tuser_i  <= op;
    s_axis_tdata_i  <= {6'b0, t, slot};
    do @(posedge clk_i); while (!s_axis_tready_o);
    items_sent++;
    if (op == OP_WRITE) begin
      if (slot < MAX_ENTRIES) table_copy[slot] = t;
    end else begin
      results_due.insert(results_due.size(), typed ? typed_res : find_predecessor(t));
    end
  endtask

  // Lower valid, wait for every outstanding result, then let the block go quiet.
  task automatic settle();
    int waited;
    waited = 0;
    s_axis_tvalid_i <= 1'b0;
    while (results_due.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk_i);
      waited++;
    end
    if (results_due.size() != 0) begin
      $error("frame_index: %0d expected results never arrived", results_due.size());
      mismatch_count++;
      results_due.delete();
    end
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_register(input logic [CFG_IDX_W-1:0] idx,
                              input logic [TIME_W-1:0] value);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    if (idx == CFG_ENTRY_COUNT) begin
      count_copy = value[CNT_REG_W-1:0];
    end else if (idx == CFG_END_TIME) begin
      end_copy = value;
    end
  endtask

  // Queries near table times and ends, with a few rewrites mixed in.
  task automatic send_queries(input int unsigned nq);
    int unsigned       pick;
    int unsigned       j;
    logic [FIDX_W-1:0] slot;
    logic [TIME_W-1:0] t;
    for (int k = 0; k < nq; k++) begin
      if ($urandom_range(0, 7) == 0) begin
        slot = FIDX_W'($urandom_range(0, MAX_ENTRIES - 1));
        t = $urandom_range(0, 1) ? table_copy[slot] : rand_time();
        send_item(OP_WRITE, slot, t, 1'b0, '0);
      end
      pick = $urandom_range(0, 9);
      if (pick <= 5 && phase_n > 0) begin
        j = $urandom_range(0, phase_n - 1);
        t = phase_times[j];
        case ($urandom_range(0, 3))
          0:       t = t - 40'd1;
          1:       t = t + 40'd1;
          2:       t = t + TIME_W'($urandom_range(0, 4095));
          default: ;
        endcase
      end else begin
        case (pick)
          6:       t = '0;
          7:       t = TIME_MAX;
          8:       t = end_copy - TIME_W'($urandom_range(0, 1));
          default: t = rand_time();
        endcase
      end
      send_item(OP_QUERY, FIDX_W'($urandom_range(0, MAX_ENTRIES - 1)), t, 1'b0, '0);
    end
  endtask

  // Queries whose probes stay on the all-left or the all-right search path.
  task automatic send_path_queries(input logic [TIME_W-1:0] t_first,
                                   input logic [TIME_W-1:0] t_one,
                                   input logic [TIME_W-1:0] t_last);
    logic [TIME_W-1:0] picks [7];
    picks = '{t_first - 40'd1, t_first, t_one - 40'd1, t_one, t_last,
              TIME_MAX - 40'd1, TIME_MAX};
    foreach (picks[p]) begin
      send_item(OP_QUERY, '0, picks[p], 1'b0, '0);
    end
  endtask

  // One random table: mostly sorted, sometimes with duplicates or out of order.
  task automatic run_random_phase(input bit with_hold);
    int unsigned       n;
    int unsigned       pick;
    int unsigned       step_cap;
    logic [TIME_W-1:0] t;
    logic [TIME_W-1:0] end_val;
    pick = $urandom_range(0, 9);
    if (pick == 0) n = 0;
    else if (pick <= 6) n = $urandom_range(1, 8);
    else if (pick <= 8) n = $urandom_range(9, 40);
    else n = $urandom_range(41, 100);

    step_cap = 4095;
    case ($urandom_range(0, 3))
      0: t = '0;
      1: begin
        t = rand_time() >> 4;
        step_cap = 1 << 20;
      end
      2: t = 40'hFF_FFF0_0000;
      default: begin
        t = rand_time() >> 16;
        step_cap = 3;
      end
    endcase
    for (int i = 0; i < n; i++) begin
      if (i > 0) t = t + TIME_W'($urandom_range(0, step_cap));
      phase_times[i] = ($urandom_range(0, 7) == 0) ? rand_time() : t;
    end

    if (n == 0) begin
      end_val = $urandom_range(0, 1) ? TIME_MAX : rand_time();
    end else begin
      case ($urandom_range(0, 5))
        0, 1:    end_val = TIME_MAX;
        2:       end_val = '0;
        3:       end_val = phase_times[n-1] + 40'd1;
        4:       end_val = phase_times[$urandom_range(0, n - 1)];
        default: end_val = rand_time();
      endcase
    end

    settle();
    set_register(CFG_ENTRY_COUNT, TIME_W'(n));
    set_register(CFG_END_TIME, end_val);
    phase_n = n;
    for (int i = 0; i < n; i++) begin
      send_item(OP_WRITE, FIDX_W'(i), phase_times[i], 1'b0, '0);
    end
    if (with_hold) begin
      hold_pending = 1'b1;
      send_queries(24);
    end else begin
      send_queries($urandom_range(4, 20));
    end
  endtask

  // Result checker: each transfer against the oldest expectation.
  always @(posedge clk_i) begin : result_check
    result_t want;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      if (results_due.size() == 0) begin
        $error("found: no result expected, got found=%0d frame_index=%0d",
               m_axis_tuser_o, m_axis_tdata_o[FIDX_W-1:0]);
        mismatch_count++;
      end else begin
        want = results_due.pop_front();
        if (m_axis_tuser_o !== want.found) begin
          $error("found: expected %0d, got %0d", want.found, m_axis_tuser_o);
          mismatch_count++;
        end
        if (m_axis_tdata_o[FIDX_W-1:0] !== want.frame_index) begin
          $error("frame_index: expected %0d, got %0d", want.frame_index,
                 m_axis_tdata_o[FIDX_W-1:0]);
          mismatch_count++;
        end
      end
    end
  end

  // Result receiver: ready bursts, short stalls and one long hold-off on request.
  initial begin : receiver
    m_axis_tready_i = 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if (hold_pending) begin
        hold_pending = 1'b0;
        m_axis_tready_i <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end else if (!quiet && $urandom_range(0, 3) == 0) begin
        m_axis_tready_i <= 1'b0;
        repeat ($urandom_range(1, 4)) @(posedge clk_i);
      end else begin
        m_axis_tready_i <= 1'b1;
        repeat ($urandom_range(1, 8)) @(posedge clk_i);
      end
    end
  end

  // Run limit.
  initial begin
    #RUN_LIMIT;
    $display("sorted_time_predecessor_search_top_tb: errors");
    $finish;
  end

  // Main sequence.
  initial begin
    logic [TIME_W-1:0] t;
    logic [TIME_W-1:0] t_first;
    logic [TIME_W-1:0] t_one;
    logic [TIME_W-1:0] t_last;
    int                phase_no;
    clk_i           = 1'b0;
    rst_ni          = 1'b0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i  = '0;
    s_axis_tuser_i  = OP_WRITE;
    cfg_we_i        = 1'b0;
    cfg_idx_i       = CFG_ENTRY_COUNT;
    cfg_data_i      = '0;
    count_copy      = '0;
    end_copy        = '0;
    mismatch_count  = 0;
    items_sent      = 0;
    quiet           = 1'b0;
    hold_pending    = 1'b0;
    phase_n         = 0;
    t_first         = '0;
    t_one           = '0;
    for (int i = 0; i < MAX_ENTRIES; i++) table_copy[i] = '0;

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed rows.
    foreach (directed_rows[r]) begin
      case (directed_rows[r].kind)
        ROW_WRITE: send_item(OP_WRITE, directed_rows[r].slot, directed_rows[r].value,
                             1'b0, '0);
        ROW_QUERY: send_item(OP_QUERY, directed_rows[r].slot, directed_rows[r].value,
                             directed_rows[r].checked,
                             {directed_rows[r].exp_found, directed_rows[r].exp_index});
        ROW_SET_COUNT: begin
          settle();
          set_register(CFG_ENTRY_COUNT, directed_rows[r].value);
        end
        default: begin
          settle();
          set_register(CFG_END_TIME, directed_rows[r].value);
        end
      endcase
    end

    // Random tables; the third one gets the long result hold-off.
    phase_no = 0;
    while (items_sent < RANDOM_ITEMS) begin
      run_random_phase(phase_no == 2);
      phase_no++;
    end

    // Largest entry count, with no idling from here on. Entry 0 and the two outer
    // search paths are written in ascending order, so every probe hits a stored time.
    quiet = 1'b1;
    settle();
    set_register(CFG_ENTRY_COUNT, TIME_W'(MAX_ENTRIES));
    set_register(CFG_END_TIME, TIME_MAX);
    t = rand_time() >> 16;
    t_first = t;
    send_item(OP_WRITE, '0, t, 1'b0, '0);
    for (int s = 1; s < MAX_ENTRIES / 2; s = s * 2) begin
      t = t + TIME_W'($urandom_range(1, 65536));
      if (s == 1) t_one = t;
      send_item(OP_WRITE, FIDX_W'(s), t, 1'b0, '0);
    end
    for (int s = MAX_ENTRIES / 2; s >= 1; s = s / 2) begin
      t = t + TIME_W'($urandom_range(1, 65536));
      send_item(OP_WRITE, FIDX_W'(MAX_ENTRIES - s), t, 1'b0, '0);
    end
    t_last = t;
    send_path_queries(t_first, t_one, t_last);
    // A count above the table size searches the whole table.
    settle();
    set_register(CFG_ENTRY_COUNT, TIME_W'(2047));
    send_path_queries(t_first, t_one, t_last);

    settle();
    if (mismatch_count == 0) begin
      $display("sorted_time_predecessor_search_top_tb: clean");
    end else begin
      $display("sorted_time_predecessor_search_top_tb: errors");
    end
    $finish;
  end

endmodule
